[sv/sba_pkg.sv]
// Shared types for the signed byte ALU: operation codes and per-stage control.
`default_nettype none
package sba_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      op_type op;
      logic   neg_a;
      logic   neg_b;
      logic   ovf;
      logic   dz;
   } ctl_type;

endpackage
`default_nettype wire

[sv/sba_step.sv]
// One pipeline stage: one shift-and-add multiply bit and one restoring divide bit.
`default_nettype none
module sba_step
   import sba_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int STEP  = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output logic                    up_ready,
   input  wire ctl_type            up_ctl,
   input  wire logic [WIDTH-1:0]   up_ma,
   input  wire logic [WIDTH-1:0]   up_mb,
   input  wire logic [2*WIDTH-1:0] up_acc,
   input  wire logic [WIDTH-1:0]   up_part,
   input  wire logic [WIDTH-1:0]   up_q,
   output logic                    dn_valid,
   input  wire logic               dn_ready,
   output ctl_type                 dn_ctl,
   output logic [WIDTH-1:0]        dn_ma,
   output logic [WIDTH-1:0]        dn_mb,
   output logic [2*WIDTH-1:0]      dn_acc,
   output logic [WIDTH-1:0]        dn_part,
   output logic [WIDTH-1:0]        dn_q
);

   logic                 valid_ff;
   ctl_type              ctl_ff;
   logic [WIDTH-1:0]     ma_ff, mb_ff, part_ff, q_ff, part_in, q_in;
   logic [2*WIDTH-1:0]   acc_ff, acc_in;
   logic [WIDTH:0]       trial;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      acc_in = up_acc;
      if (up_ctl.op == OP_MUL && up_mb[STEP]) begin
         acc_in = up_acc + ({{WIDTH{1'b0}}, up_ma} << STEP);
      end
      trial   = {up_part, up_ma[WIDTH-1-STEP]};
      part_in = up_part;
      q_in    = up_q;
      if (up_ctl.op == OP_DIV) begin
         if (trial >= {1'b0, up_mb}) begin
            part_in = WIDTH'(trial - {1'b0, up_mb});
            q_in    = {up_q[WIDTH-2:0], 1'b1};
         end else begin
            part_in = trial[WIDTH-1:0];
            q_in    = {up_q[WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         ctl_ff  <= up_ctl;
         ma_ff   <= up_ma;
         mb_ff   <= up_mb;
         acc_ff  <= acc_in;
         part_ff <= part_in;
         q_ff    <= q_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_ctl   = ctl_ff;
   assign dn_ma    = ma_ff;
   assign dn_mb    = mb_ff;
   assign dn_acc   = acc_ff;
   assign dn_part  = part_ff;
   assign dn_q     = q_ff;

endmodule
`default_nettype wire

[sv/signed_byte_alu.sv]
// Signed ALU top level: add, subtract, multiply and divide on two's-complement operands.
// Stages: input stage, one stage per operand bit, output stage.
// Throughput: one request per cycle if not stalled; each stage has its own ready, so bubbles
// collapse and a stalled result does not block new requests while any stage is empty.
// Reset: synchronous, active high; clears the stage valid bits only.
`default_nettype none
module signed_byte_alu
   import sba_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // operation[1:0], operand_a, operand_b, zero pad
   input  wire logic [((2*WIDTH+2+7)/8)*8-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // main_result, remainder, overflow, divide_by_zero, zero pad
   output logic [((3*WIDTH+2+7)/8)*8-1:0]          rsp_tdata
);

   localparam int RSP_BITS = ((3*WIDTH+2+7)/8)*8;

   logic               v_s    [0:WIDTH];
   logic               rdy_s  [0:WIDTH];
   ctl_type            ctl_s  [0:WIDTH];
   logic [WIDTH-1:0]   ma_s   [0:WIDTH];
   logic [WIDTH-1:0]   mb_s   [0:WIDTH];
   logic [2*WIDTH-1:0] acc_s  [0:WIDTH];
   logic [WIDTH-1:0]   part_s [0:WIDTH];
   logic [WIDTH-1:0]   q_s    [0:WIDTH];

   // input stage
   op_type             op_c;
   logic [WIDTH-1:0]   a_c, b_c, sum_c, diff_c;
   ctl_type            pre_ctl_in, pre_ctl_ff;
   logic [WIDTH-1:0]   pre_ma_in, pre_mb_in, pre_ma_ff, pre_mb_ff;
   logic [2*WIDTH-1:0] pre_acc_in, pre_acc_ff;
   logic               pre_valid_ff;

   assign op_c   = op_type'(req_tdata[1:0]);
   assign a_c    = req_tdata[WIDTH+1:2];
   assign b_c    = req_tdata[2*WIDTH+1:WIDTH+2];
   assign sum_c  = a_c + b_c;
   assign diff_c = a_c - b_c;

   always_comb begin
      pre_ctl_in.op    = op_c;
      pre_ctl_in.neg_a = a_c[WIDTH-1];
      pre_ctl_in.neg_b = b_c[WIDTH-1];
      pre_ctl_in.ovf   = 1'b0;
      pre_ctl_in.dz    = 1'b0;
      pre_ma_in  = a_c[WIDTH-1] ? WIDTH'(~a_c + 1'b1) : a_c;
      pre_mb_in  = b_c[WIDTH-1] ? WIDTH'(~b_c + 1'b1) : b_c;
      pre_acc_in = '0;
      case (op_c)
         OP_ADD: begin
            pre_acc_in     = {{WIDTH{1'b0}}, sum_c};
            pre_ctl_in.ovf = (a_c[WIDTH-1] == b_c[WIDTH-1]) &&
                             (sum_c[WIDTH-1] != a_c[WIDTH-1]);
         end
         OP_SUB: begin
            pre_acc_in     = {{WIDTH{1'b0}}, diff_c};
            pre_ctl_in.ovf = (a_c[WIDTH-1] != b_c[WIDTH-1]) &&
                             (diff_c[WIDTH-1] != a_c[WIDTH-1]);
         end
         OP_DIV: begin
            pre_ctl_in.dz  = (b_c == '0);
            pre_ctl_in.ovf = (a_c == {1'b1, {(WIDTH-1){1'b0}}}) && (b_c == '1);
         end
         default: begin
         end
      endcase
   end

   assign req_tready = !pre_valid_ff || rdy_s[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (req_tready) begin
         pre_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         pre_ctl_ff <= pre_ctl_in;
         pre_ma_ff  <= pre_ma_in;
         pre_mb_ff  <= pre_mb_in;
         pre_acc_ff <= pre_acc_in;
      end
   end

   assign v_s[0]    = pre_valid_ff;
   assign ctl_s[0]  = pre_ctl_ff;
   assign ma_s[0]   = pre_ma_ff;
   assign mb_s[0]   = pre_mb_ff;
   assign acc_s[0]  = pre_acc_ff;
   assign part_s[0] = '0;
   assign q_s[0]    = '0;

   // one stage per operand bit, MSB first for divide
   for (genvar k = 0; k < WIDTH; k++) begin : g_step
      sba_step #(
         .WIDTH (WIDTH),
         .STEP  (k)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .up_valid (v_s[k]),
         .up_ready (rdy_s[k]),
         .up_ctl   (ctl_s[k]),
         .up_ma    (ma_s[k]),
         .up_mb    (mb_s[k]),
         .up_acc   (acc_s[k]),
         .up_part  (part_s[k]),
         .up_q     (q_s[k]),
         .dn_valid (v_s[k+1]),
         .dn_ready (rdy_s[k+1]),
         .dn_ctl   (ctl_s[k+1]),
         .dn_ma    (ma_s[k+1]),
         .dn_mb    (mb_s[k+1]),
         .dn_acc   (acc_s[k+1]),
         .dn_part  (part_s[k+1]),
         .dn_q     (q_s[k+1])
      );
   end

   // output stage: sign fixes and formatting
   ctl_type            fin_ctl;
   logic [2*WIDTH-1:0] fin_acc;
   logic [WIDTH-1:0]   fin_part, fin_q;
   logic [2*WIDTH-1:0] post_main_in, post_main_ff;
   logic [WIDTH-1:0]   post_rem_in, post_rem_ff;
   logic               post_ovf_in, post_ovf_ff, post_dz_in, post_dz_ff;
   logic               post_valid_ff;
   logic [WIDTH-1:0]   q_signed;

   assign fin_ctl  = ctl_s[WIDTH];
   assign fin_acc  = acc_s[WIDTH];
   assign fin_part = part_s[WIDTH];
   assign fin_q    = q_s[WIDTH];
   assign q_signed = (fin_ctl.neg_a != fin_ctl.neg_b) ? WIDTH'(~fin_q + 1'b1) : fin_q;

   always_comb begin
      post_main_in = '0;
      post_rem_in  = '0;
      post_ovf_in  = fin_ctl.ovf;
      post_dz_in   = 1'b0;
      case (fin_ctl.op)
         OP_ADD, OP_SUB: begin
            post_main_in = {{WIDTH{fin_acc[WIDTH-1]}}, fin_acc[WIDTH-1:0]};
         end
         OP_MUL: begin
            post_main_in = (fin_ctl.neg_a != fin_ctl.neg_b) ?
                           (2*WIDTH)'(~fin_acc + 1'b1) : fin_acc;
            post_ovf_in  = 1'b0;
         end
         OP_DIV: begin
            post_rem_in = fin_ctl.neg_a ? WIDTH'(~fin_part + 1'b1) : fin_part;
            post_dz_in  = fin_ctl.dz;
            if (fin_ctl.dz) begin
               post_main_in = '1;
            end else begin
               post_main_in = {{WIDTH{q_signed[WIDTH-1]}}, q_signed};
            end
         end
         default: begin
         end
      endcase
   end

   assign rdy_s[WIDTH] = !post_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         post_valid_ff <= 1'b0;
      end else if (rdy_s[WIDTH]) begin
         post_valid_ff <= v_s[WIDTH];
      end
      if (rdy_s[WIDTH] && v_s[WIDTH]) begin
         post_main_ff <= post_main_in;
         post_rem_ff  <= post_rem_in;
         post_ovf_ff  <= post_ovf_in;
         post_dz_ff   <= post_dz_in;
      end
   end

   assign rsp_tvalid = post_valid_ff;
   assign rsp_tdata  = RSP_BITS'({post_dz_ff, post_ovf_ff, post_rem_ff, post_main_ff});

endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for signed_byte_alu: directed and random requests, checked by table or predictor.
`timescale 1ns / 100ps
module tb;
   import sba_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_REQUESTS = 430;
   localparam int STEADY_TAIL = 60;
   localparam logic [7:0] MOST_NEG = 8'h80;
   localparam logic [7:0] MINUS_ONE = 8'hFF;

   typedef struct packed {
      op_type            op;
      logic signed [7:0] a;
      logic signed [7:0] b;
   } alu_request_type;

   typedef struct packed {
      logic signed [15:0] main_result;
      logic signed [7:0]  remainder;
      logic               overflow;
      logic               divide_by_zero;
   } alu_result_type;

   typedef struct packed {
      alu_request_type request;
      logic            typed;
      alu_result_type  result;
   } stimulus_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // operation[1:0], operand_a, operand_b, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;        // main_result, remainder, overflow, divide_by_zero, zero pad

   logic steady_tail = 1'b0;
   alu_result_type pending_results[$];
   stimulus_row_type directed_table[$];
   int mismatches = 0;
   int results_checked = 0;
   int zero_divisors = 0;
   int overflows = 0;
   int op_count[4] = '{0, 0, 0, 0};
   int idle_cycles = 0;

   signed_byte_alu #(.WIDTH(8)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic alu_result_type alu_compute(alu_request_type r);
      alu_result_type res;
      logic [7:0]  sum, mag_a, mag_b, quo, rem;
      logic [15:0] prod;
      logic        na, nb;
      res = '0;
      na = r.a[7];
      nb = r.b[7];
      mag_a = na ? (~r.a + 8'd1) : r.a;
      mag_b = nb ? (~r.b + 8'd1) : r.b;
      case (r.op)
         OP_ADD: begin
            sum = r.a + r.b;
            res.main_result = {{8{sum[7]}}, sum};
            res.overflow = (na == nb) && (sum[7] != na);
         end
         OP_SUB: begin
            sum = r.a - r.b;
            res.main_result = {{8{sum[7]}}, sum};
            res.overflow = (na != nb) && (sum[7] != na);
         end
         OP_MUL: begin
            prod = {8'd0, mag_a} * {8'd0, mag_b};
            if (na != nb) prod = ~prod + 16'd1;
            res.main_result = prod;
         end
         default: begin
            if (r.b[7:0] == 8'd0) begin
               res.main_result = 16'hFFFF;
               res.remainder = r.a;
               res.divide_by_zero = 1'b1;
            end else begin
               quo = mag_a / mag_b;
               rem = mag_a % mag_b;
               res.overflow = (r.a[7:0] == MOST_NEG) && (r.b[7:0] == MINUS_ONE);
               if (na != nb) quo = ~quo + 8'd1;
               if (na) rem = ~rem + 8'd1;
               res.main_result = {{8{quo[7]}}, quo};
               res.remainder = rem;
            end
         end
      endcase
      return res;
   endfunction

   function automatic stimulus_row_type checked_row(op_type op, logic [7:0] a, logic [7:0] b,
         logic [15:0] main, logic [7:0] rem, logic ovf, logic dz);
      stimulus_row_type row;
      row.request = {op, a, b};
      row.typed = 1'b1;
      row.result = {main, rem, ovf, dz};
      return row;
   endfunction

   function automatic stimulus_row_type predicted_row(op_type op, logic [7:0] a, logic [7:0] b);
      stimulus_row_type row;
      row.request = {op, a, b};
      row.typed = 1'b0;
      row.result = '0;
      return row;
   endfunction

   function automatic logic [7:0] pick_operand();
      logic [7:0] corners[5];
      corners = '{MOST_NEG, MINUS_ONE, 8'h00, 8'h01, 8'h7F};
      if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 4)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_request(alu_request_type r, alu_result_type want);
      if (!steady_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, r.b, r.a, r.op};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(want);
      op_count[r.op]++;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // result stalls: random busy stretches, then a random stall unless in the steady tail
   initial begin
      int busy;
      forever begin
         busy = $urandom_range(1, 30);
         repeat (busy) @(posedge clock);
         if (!steady_tail) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      alu_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[23:16], rsp_tdata[24], rsp_tdata[25]};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result main=%h rem=%h ovf=%b dz=%b",
                  got.main_result, got.remainder, got.overflow, got.divide_by_zero);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            zero_divisors += want.divide_by_zero;
            overflows += want.overflow;
            if (got.main_result !== want.main_result || got.remainder !== want.remainder ||
                  got.overflow !== want.overflow || got.divide_by_zero !== want.divide_by_zero) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected main=%h rem=%h ovf=%b dz=%b, got main=%h rem=%h ovf=%b dz=%b",
                     results_checked, want.main_result, want.remainder, want.overflow,
                     want.divide_by_zero, got.main_result, got.remainder, got.overflow,
                     got.divide_by_zero);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("signed_byte_alu: mismatch");
         $finish;
      end
   end

   initial begin
      alu_request_type request;
      alu_result_type want;
      directed_table.push_back(checked_row(OP_ADD, 8'd127, 8'd1, 16'hFF80, 8'h00, 1'b1, 1'b0));
      directed_table.push_back(checked_row(OP_ADD, MOST_NEG, MINUS_ONE, 16'h007F, 8'h00, 1'b1, 1'b0));
      directed_table.push_back(checked_row(OP_ADD, MOST_NEG, 8'd127, 16'hFFFF, 8'h00, 1'b0, 1'b0));
      directed_table.push_back(checked_row(OP_ADD, 8'd0, 8'd0, 16'h0000, 8'h00, 1'b0, 1'b0));
      directed_table.push_back(predicted_row(OP_ADD, MINUS_ONE, 8'd1));
      directed_table.push_back(checked_row(OP_SUB, MOST_NEG, 8'd1, 16'h007F, 8'h00, 1'b1, 1'b0));
      directed_table.push_back(checked_row(OP_SUB, 8'd0, MOST_NEG, 16'hFF80, 8'h00, 1'b1, 1'b0));
      directed_table.push_back(checked_row(OP_SUB, MINUS_ONE, MOST_NEG, 16'h007F, 8'h00, 1'b0, 1'b0));
      directed_table.push_back(checked_row(OP_SUB, 8'd127, MINUS_ONE, 16'hFF80, 8'h00, 1'b1, 1'b0));
      directed_table.push_back(predicted_row(OP_SUB, 8'd5, 8'd9));
      directed_table.push_back(checked_row(OP_MUL, MOST_NEG, MOST_NEG, 16'h4000, 8'h00, 1'b0, 1'b0));
      directed_table.push_back(checked_row(OP_MUL, 8'd127, MOST_NEG, 16'hC080, 8'h00, 1'b0, 1'b0));
      directed_table.push_back(checked_row(OP_MUL, MINUS_ONE, MINUS_ONE, 16'h0001, 8'h00, 1'b0, 1'b0));
      directed_table.push_back(checked_row(OP_MUL, 8'd0, MOST_NEG, 16'h0000, 8'h00, 1'b0, 1'b0));
      directed_table.push_back(checked_row(OP_MUL, 8'd127, 8'd127, 16'h3F01, 8'h00, 1'b0, 1'b0));
      directed_table.push_back(predicted_row(OP_MUL, 8'hFD, 8'd5));
      directed_table.push_back(checked_row(OP_DIV, 8'd5, 8'd0, 16'hFFFF, 8'h05, 1'b0, 1'b1));
      directed_table.push_back(checked_row(OP_DIV, MOST_NEG, 8'd0, 16'hFFFF, 8'h80, 1'b0, 1'b1));
      directed_table.push_back(checked_row(OP_DIV, MOST_NEG, MINUS_ONE, 16'hFF80, 8'h00, 1'b1, 1'b0));
      directed_table.push_back(checked_row(OP_DIV, MOST_NEG, 8'd1, 16'hFF80, 8'h00, 1'b0, 1'b0));
      directed_table.push_back(checked_row(OP_DIV, 8'd127, MOST_NEG, 16'h0000, 8'h7F, 1'b0, 1'b0));
      directed_table.push_back(checked_row(OP_DIV, MOST_NEG, MOST_NEG, 16'h0001, 8'h00, 1'b0, 1'b0));
      directed_table.push_back(predicted_row(OP_DIV, 8'hF9, 8'd2));
      directed_table.push_back(predicted_row(OP_DIV, 8'd7, 8'hFE));
      directed_table.push_back(predicted_row(OP_DIV, 8'd100, 8'd7));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_table[i]) begin
         want = directed_table[i].typed ? directed_table[i].result
                                        : alu_compute(directed_table[i].request);
         send_request(directed_table[i].request, want);
      end
      wait_for_drain();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 2) wait_for_drain();
         if (n == RANDOM_REQUESTS - STEADY_TAIL) steady_tail = 1'b1;
         request.op = op_type'($urandom_range(0, 3));
         request.a = pick_operand();
         request.b = pick_operand();
         send_request(request, alu_compute(request));
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("requests: %0d add, %0d subtract, %0d multiply, %0d divide",
         op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV]);
      $display("results checked: %0d, of them %0d zero-divisor and %0d overflow",
         results_checked, zero_divisors, overflows);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("signed_byte_alu: match");
      else
         $display("signed_byte_alu: mismatch");
      $finish;
   end

endmodule

[filelist.f]
sv/sba_pkg.sv
sv/sba_step.sv
sv/signed_byte_alu.sv
test/tb.sv
